/* rtl/segment_crossing_test_macros.svh */
// Assertion macros for the segment crossing test block.
// Used by the top level only; needs nothing else.
`ifndef SEGMENT_CROSSING_TEST_MACROS_SVH
`define SEGMENT_CROSSING_TEST_MACROS_SVH

// Same-cycle implication: when cond holds, prop holds in that cycle.
`define SCT_ASSERT_IMPL(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication: when cond holds, prop holds in the next cycle.
`define SCT_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* rtl/sct_pkg.sv */
// Shared constants and types of the segment crossing test block.
// Depends on nothing; used by sct_divider, segment_crossing_test, the checker and the testbench.
package sct_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int TOL_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 8;

    localparam logic [TOL_WIDTH-1:0] NEAR_TOL_RESET = 16'd7;
    localparam logic [TOL_WIDTH-1:0] EDGE_TOL_RESET = 16'd6554;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NEAR_TOL = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_TOL = 8'd1;

    localparam logic [1:0] OP_GENERAL = 2'd0;
    localparam logic [1:0] OP_HORIZ   = 2'd1;
    localparam logic [1:0] OP_VERT    = 2'd2;

    // Pipeline step control handed to the divider.
    typedef struct packed {
        logic adv;
        logic valid;
    } sct_step_ctl_t;

endpackage

/* rtl/sct_divider.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage, with a sideband.
// Depends on sct_pkg for the step control struct.
module sct_divider #(
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 4,
    parameter int STEPS  = 4,
    parameter int SIDE_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sct_pkg::sct_step_ctl_t      ctl,
    input  logic [NUM_W-1:0]            num,
    input  logic [DEN_W-1:0]            den,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic [STEPS-1:0]            quot,
    output logic [SIDE_W-1:0]           side_out
);

    // The numerator bits above STEPS go straight into the remainder; the caller
    // guarantees that they are below the divisor.
    logic [DEN_W-1:0]  rem_reg  [STEPS+1];
    logic [STEPS-1:0]  bits_reg [STEPS+1];
    logic [DEN_W-1:0]  den_reg  [STEPS+1];
    logic [SIDE_W-1:0] side_reg [STEPS+1];
    logic [STEPS:0]    vld_reg;

    logic [DEN_W-1:0]  rem_next  [STEPS];
    logic [STEPS-1:0]  bits_next [STEPS];

    always_comb begin
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        for (int k = 0; k < STEPS; k++) begin
            trial = {rem_reg[k], bits_reg[k][STEPS-1]};
            diff  = trial - {1'b0, den_reg[k]};
            ge    = trial >= {1'b0, den_reg[k]};
            rem_next[k]  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            bits_next[k] = {bits_reg[k][STEPS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl.adv) begin
            vld_reg <= {vld_reg[STEPS-1:0], ctl.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            rem_reg[0]  <= DEN_W'(num[NUM_W-1:STEPS]);
            bits_reg[0] <= num[STEPS-1:0];
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            for (int k = 0; k < STEPS; k++) begin
                rem_reg[k+1]  <= rem_next[k];
                bits_reg[k+1] <= bits_next[k];
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign quot      = bits_reg[STEPS];
    assign side_out  = side_reg[STEPS];

endmodule

/* rtl/segment_crossing_test.sv */
// Top level of the segment crossing test: stream ports, tolerance registers and pipeline.
// Depends on sct_pkg, sct_divider and segment_crossing_test_macros.svh.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid/s_tready    tuser opcode, tdata eight coordinates
//  m_       out        m_tvalid/m_tready    tuser hit, tdata contact x and y
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data (tolerance)
//
// One item enters per cycle while the output is not stalled; each result passes through the
// input stages, the bit-per-stage dividers, the post stages and the output register.
// Reset is synchronous and active low; it clears the valid bits and loads the
// tolerance defaults. A stalled output freezes the whole pipeline, so nothing is
// dropped or repeated, and the input is ready again as soon as the output moves.
`include "segment_crossing_test_macros.svh"

module segment_crossing_test #(
    parameter int COORD_WIDTH = sct_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = sct_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // surf_x0, surf_y0, surf_x1, surf_y1, move_ax, move_ay, move_bx, move_by
    input  logic [8*COORD_WIDTH-1:0]              s_tdata,
    // opcode
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // contact_x, contact_y, zero padding
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
    // hit
    output logic                                  m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sct_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [sct_pkg::TOL_WIDTH-1:0]         cfg_data
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = CW + 1;
    localparam int MW     = 2 * DW;
    localparam int PW     = MW + 1;
    localparam int QSTEPS = (CW + 2 > FRAC_BITS) ? CW + 2 : FRAC_BITS;
    localparam int GD_W   = PW - 1;
    localparam int GN_W   = GD_W + FRAC_BITS;
    localparam int GP_W   = DW + FRAC_BITS + 2;
    localparam int UW     = QSTEPS + 2;
    localparam int OUT_W  = ((2 * CW + 7) / 8) * 8;

    localparam logic [FRAC_BITS:0] G_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic signed [GP_W-1:0] G_BIAS = GP_W'((1 << FRAC_BITS) - 1);

    typedef struct packed {
        logic [1:0]             op;
        logic                   tzero;
        logic                   tone;
        logic                   miss;
        logic signed [DW-1:0]   aw;
        logic signed [DW-1:0]   ah;
        logic signed [CW-1:0]   x0;
        logic signed [CW-1:0]   y0;
    } g_side_t;

    typedef struct packed {
        logic                   miss;
        logic                   qneg;
        logic signed [CW-1:0]   ua;
        logic signed [CW-1:0]   lo;
        logic signed [CW-1:0]   hi;
    } a_side_t;

    // Configuration.
    logic [sct_pkg::TOL_WIDTH-1:0] near_tol_reg;
    logic [sct_pkg::TOL_WIDTH-1:0] edge_tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_tol_reg <= sct_pkg::NEAR_TOL_RESET;
            edge_tol_reg <= sct_pkg::EDGE_TOL_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == sct_pkg::REG_NEAR_TOL) begin
                near_tol_reg <= cfg_data;
            end else if (cfg_index == sct_pkg::REG_EDGE_TOL) begin
                edge_tol_reg <= cfg_data;
            end
        end
    end

    logic signed [DW-1:0] a_nt;
    logic signed [PW-1:0] g_nt;
    logic signed [PW-1:0] g_et;
    logic signed [UW-1:0] a_et;

    assign a_nt = signed'(DW'(near_tol_reg));
    assign g_nt = signed'(PW'(near_tol_reg) << FRAC_BITS);
    assign g_et = signed'(PW'(edge_tol_reg) << FRAC_BITS);
    assign a_et = signed'(UW'(edge_tol_reg));

    logic pipe_adv;
    logic out_valid_reg;

    assign pipe_adv = !out_valid_reg || m_tready;
    assign s_tready = pipe_adv;

    // Stage 1: differences, general bounding boxes, axis operand selection.
    logic signed [CW-1:0] in_x0, in_y0, in_x1, in_y1, in_ax, in_ay, in_bx, in_by;

    assign in_x0 = s_tdata[0*CW +: CW];
    assign in_y0 = s_tdata[1*CW +: CW];
    assign in_x1 = s_tdata[2*CW +: CW];
    assign in_y1 = s_tdata[3*CW +: CW];
    assign in_ax = s_tdata[4*CW +: CW];
    assign in_ay = s_tdata[5*CW +: CW];
    assign in_bx = s_tdata[6*CW +: CW];
    assign in_by = s_tdata[7*CW +: CW];

    logic signed [CW-1:0] s1_c_next, s1_s0, s1_s1, s1_ua_next, s1_va_next;
    logic signed [CW-1:0] s1_ub_next, s1_vb_next;
    logic                 s1_below_next, s1_gbox_next;
    logic signed [CW-1:0] g_minx, g_maxx, g_miny, g_maxy;

    always_comb begin
        case (s_tuser)
            sct_pkg::OP_VERT: begin
                s1_c_next     = in_x0;
                s1_s0         = in_y0;
                s1_s1         = in_y1;
                s1_ua_next    = in_ay;
                s1_va_next    = in_ax;
                s1_ub_next    = in_by;
                s1_vb_next    = in_bx;
                s1_below_next = !(in_y0 < in_y1);
            end
            default: begin
                s1_c_next     = in_y0;
                s1_s0         = in_x0;
                s1_s1         = in_x1;
                s1_ua_next    = in_ax;
                s1_va_next    = in_ay;
                s1_ub_next    = in_bx;
                s1_vb_next    = in_by;
                s1_below_next = in_x0 < in_x1;
            end
        endcase
        g_minx = (in_x0 < in_x1) ? in_x0 : in_x1;
        g_maxx = (in_x0 < in_x1) ? in_x1 : in_x0;
        g_miny = (in_y0 < in_y1) ? in_y0 : in_y1;
        g_maxy = (in_y0 < in_y1) ? in_y1 : in_y0;
        s1_gbox_next = (in_ax < g_minx && in_bx < g_minx) ||
                       (g_maxx < in_ax && g_maxx < in_bx) ||
                       (in_ay < g_miny && in_by < g_miny) ||
                       (g_maxy < in_ay && g_maxy < in_by);
    end

    logic                 s1_valid_reg;
    logic [1:0]           s1_op_reg;
    logic signed [CW-1:0] s1_x0_reg, s1_y0_reg;
    logic signed [DW-1:0] s1_aw_reg, s1_ah_reg, s1_d0x_reg, s1_d0y_reg;
    logic signed [DW-1:0] s1_d1x_reg, s1_d1y_reg, s1_bw_reg, s1_bh_reg;
    logic                 s1_gbox_reg, s1_below_reg;
    logic signed [CW-1:0] s1_c_reg, s1_lo_reg, s1_hi_reg;
    logic signed [CW-1:0] s1_ua_reg, s1_va_reg, s1_ub_reg, s1_vb_reg;

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            s1_op_reg    <= s_tuser;
            s1_x0_reg    <= in_x0;
            s1_y0_reg    <= in_y0;
            s1_aw_reg    <= DW'(in_x1) - DW'(in_x0);
            s1_ah_reg    <= DW'(in_y1) - DW'(in_y0);
            s1_d0x_reg   <= DW'(in_ax) - DW'(in_x0);
            s1_d0y_reg   <= DW'(in_ay) - DW'(in_y0);
            s1_d1x_reg   <= DW'(in_bx) - DW'(in_x1);
            s1_d1y_reg   <= DW'(in_by) - DW'(in_y1);
            s1_bw_reg    <= DW'(in_bx) - DW'(in_ax);
            s1_bh_reg    <= DW'(in_by) - DW'(in_ay);
            s1_gbox_reg  <= s1_gbox_next;
            s1_below_reg <= s1_below_next;
            s1_c_reg     <= s1_c_next;
            s1_lo_reg    <= (s1_s0 < s1_s1) ? s1_s0 : s1_s1;
            s1_hi_reg    <= (s1_s0 < s1_s1) ? s1_s1 : s1_s0;
            s1_ua_reg    <= s1_ua_next;
            s1_va_reg    <= s1_va_next;
            s1_ub_reg    <= s1_ub_next;
            s1_vb_reg    <= s1_vb_next;
        end
    end

    // Stage 2: general products; axis side tests and differences.
    logic signed [DW-1:0] s2_dva, s2_dvb;
    logic                 s2_amiss_next;

    always_comb begin
        s2_dva = DW'(s1_va_reg) - DW'(s1_c_reg);
        s2_dvb = DW'(s1_vb_reg) - DW'(s1_c_reg);
        s2_amiss_next = (s1_ua_reg < s1_lo_reg && s1_ub_reg < s1_lo_reg) ||
                        (s1_hi_reg < s1_ua_reg && s1_hi_reg < s1_ub_reg);
        if (s1_below_reg) begin
            s2_amiss_next = s2_amiss_next || (s2_dva < -a_nt) || (s2_dvb > a_nt);
        end else begin
            s2_amiss_next = s2_amiss_next || (s2_dvb < -a_nt) || (s2_dva > a_nt);
        end
    end

    logic                 s2_valid_reg;
    logic [1:0]           s2_op_reg;
    logic signed [CW-1:0] s2_x0_reg, s2_y0_reg;
    logic signed [DW-1:0] s2_aw_reg, s2_ah_reg;
    logic                 s2_gmiss_reg;
    logic signed [MW-1:0] s2_h0a_reg, s2_h0b_reg, s2_h1a_reg, s2_h1b_reg;
    logic signed [MW-1:0] s2_dta_reg, s2_dtb_reg, s2_ara_reg, s2_arb_reg;
    logic signed [MW-1:0] s2_nma_reg, s2_nmb_reg;
    logic                 s2_amiss_reg;
    logic signed [DW-1:0] s2_du_reg, s2_dv_reg, s2_cva_reg;
    logic signed [CW-1:0] s2_ua_reg, s2_lo_reg, s2_hi_reg;

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            s2_op_reg    <= s1_op_reg;
            s2_x0_reg    <= s1_x0_reg;
            s2_y0_reg    <= s1_y0_reg;
            s2_aw_reg    <= s1_aw_reg;
            s2_ah_reg    <= s1_ah_reg;
            s2_gmiss_reg <= s1_gbox_reg || (s1_bw_reg == '0 && s1_bh_reg == '0);
            s2_h0a_reg   <= MW'(s1_aw_reg) * MW'(s1_d0y_reg);
            s2_h0b_reg   <= MW'(s1_ah_reg) * MW'(s1_d0x_reg);
            s2_h1a_reg   <= MW'(s1_aw_reg) * MW'(s1_d1y_reg);
            s2_h1b_reg   <= MW'(s1_ah_reg) * MW'(s1_d1x_reg);
            s2_dta_reg   <= MW'(s1_d0x_reg) * MW'(s1_d1y_reg);
            s2_dtb_reg   <= MW'(s1_d0y_reg) * MW'(s1_d1x_reg);
            s2_ara_reg   <= MW'(s1_bw_reg) * MW'(s1_ah_reg);
            s2_arb_reg   <= MW'(s1_bh_reg) * MW'(s1_aw_reg);
            s2_nma_reg   <= MW'(s1_bw_reg) * MW'(s1_d0y_reg);
            s2_nmb_reg   <= MW'(s1_bh_reg) * MW'(s1_d0x_reg);
            s2_amiss_reg <= s2_amiss_next;
            s2_du_reg    <= DW'(s1_ub_reg) - DW'(s1_ua_reg);
            s2_dv_reg    <= DW'(s1_vb_reg) - DW'(s1_va_reg);
            s2_cva_reg   <= DW'(s1_c_reg) - DW'(s1_va_reg);
            s2_ua_reg    <= s1_ua_reg;
            s2_lo_reg    <= s1_lo_reg;
            s2_hi_reg    <= s1_hi_reg;
        end
    end

    // Stage 3: side values, determinant, area, numerator; axis product.
    logic                 s3_valid_reg;
    logic [1:0]           s3_op_reg;
    logic signed [CW-1:0] s3_x0_reg, s3_y0_reg;
    logic signed [DW-1:0] s3_aw_reg, s3_ah_reg;
    logic                 s3_gmiss_reg;
    logic signed [PW-1:0] s3_h0_reg, s3_h1_reg, s3_det_reg, s3_area_reg, s3_num_reg;
    logic                 s3_amiss_reg, s3_dvneg_reg;
    logic signed [MW-1:0] s3_prod_reg;
    logic [DW-1:0]        s3_absdv_reg;
    logic signed [CW-1:0] s3_ua_reg, s3_lo_reg, s3_hi_reg;

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            s3_op_reg    <= s2_op_reg;
            s3_x0_reg    <= s2_x0_reg;
            s3_y0_reg    <= s2_y0_reg;
            s3_aw_reg    <= s2_aw_reg;
            s3_ah_reg    <= s2_ah_reg;
            s3_gmiss_reg <= s2_gmiss_reg;
            s3_h0_reg    <= PW'(s2_h0a_reg) - PW'(s2_h0b_reg);
            s3_h1_reg    <= PW'(s2_h1a_reg) - PW'(s2_h1b_reg);
            s3_det_reg   <= PW'(s2_dta_reg) - PW'(s2_dtb_reg);
            s3_area_reg  <= PW'(s2_ara_reg) - PW'(s2_arb_reg);
            s3_num_reg   <= PW'(s2_nma_reg) - PW'(s2_nmb_reg);
            // A zero motion extent on the divisor axis misses even with a zero tolerance.
            s3_amiss_reg <= s2_amiss_reg || (s2_dv_reg == '0) ||
                            (s2_dv_reg < a_nt && s2_dv_reg > -a_nt);
            s3_dvneg_reg <= s2_dv_reg[DW-1];
            s3_absdv_reg <= DW'(s2_dv_reg[DW-1] ? -s2_dv_reg : s2_dv_reg);
            s3_prod_reg  <= MW'(s2_du_reg) * MW'(s2_cva_reg);
            s3_ua_reg    <= s2_ua_reg;
            s3_lo_reg    <= s2_lo_reg;
            s3_hi_reg    <= s2_hi_reg;
        end
    end

    // Stage 4: general rejection, magnitudes for both divisions.
    logic s4_gmiss_next;

    always_comb begin
        // A positive side value at B always rejects, whatever the side of A.
        s4_gmiss_next = s3_gmiss_reg ||
                        (s3_h0_reg < -g_et) ||
                        (s3_h1_reg > PW'(0)) ||
                        (s3_h0_reg == '0 && s3_h1_reg == '0) ||
                        (s3_det_reg < s3_h0_reg && s3_det_reg < s3_h1_reg) ||
                        (s3_det_reg > s3_h0_reg && s3_det_reg > s3_h1_reg) ||
                        !(s3_area_reg > g_nt || s3_area_reg < -g_nt);
    end

    logic                 s4_valid_reg;
    logic [1:0]           s4_op_reg;
    logic signed [CW-1:0] s4_x0_reg, s4_y0_reg;
    logic signed [DW-1:0] s4_aw_reg, s4_ah_reg;
    logic                 s4_gmiss_reg, s4_tzero_reg;
    logic [GD_W-1:0]      s4_absnum_reg, s4_absarea_reg;
    logic                 s4_amiss_reg, s4_qneg_reg;
    logic [MW-1:0]        s4_absprod_reg;
    logic [DW-1:0]        s4_absdv_reg;
    logic signed [CW-1:0] s4_ua_reg, s4_lo_reg, s4_hi_reg;

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            s4_op_reg      <= s3_op_reg;
            s4_x0_reg      <= s3_x0_reg;
            s4_y0_reg      <= s3_y0_reg;
            s4_aw_reg      <= s3_aw_reg;
            s4_ah_reg      <= s3_ah_reg;
            s4_gmiss_reg   <= s4_gmiss_next;
            s4_tzero_reg   <= (s3_num_reg == '0) || (s3_num_reg[PW-1] != s3_area_reg[PW-1]);
            s4_absnum_reg  <= GD_W'(s3_num_reg[PW-1] ? -s3_num_reg : s3_num_reg);
            s4_absarea_reg <= GD_W'(s3_area_reg[PW-1] ? -s3_area_reg : s3_area_reg);
            s4_amiss_reg   <= s3_amiss_reg;
            s4_qneg_reg    <= s3_prod_reg[MW-1] != s3_dvneg_reg;
            s4_absprod_reg <= MW'(s3_prod_reg[MW-1] ? -s3_prod_reg : s3_prod_reg);
            s4_absdv_reg   <= s3_absdv_reg;
            s4_ua_reg      <= s3_ua_reg;
            s4_lo_reg      <= s3_lo_reg;
            s4_hi_reg      <= s3_hi_reg;
        end
    end

    // Dividers: t for the general case, the crossing offset for the axis cases.
    sct_pkg::sct_step_ctl_t div_ctl;
    g_side_t                g_side_in, g_side_out;
    a_side_t                a_side_in, a_side_out;
    logic                   g_div_valid, a_div_valid;
    logic [QSTEPS-1:0]      g_quot, a_quot;

    assign div_ctl.adv   = pipe_adv;
    assign div_ctl.valid = s4_valid_reg;

    assign g_side_in.op    = s4_op_reg;
    assign g_side_in.tzero = s4_tzero_reg;
    assign g_side_in.tone  = s4_absnum_reg >= s4_absarea_reg;
    assign g_side_in.miss  = s4_gmiss_reg;
    assign g_side_in.aw    = s4_aw_reg;
    assign g_side_in.ah    = s4_ah_reg;
    assign g_side_in.x0    = s4_x0_reg;
    assign g_side_in.y0    = s4_y0_reg;

    assign a_side_in.miss = s4_amiss_reg;
    assign a_side_in.qneg = s4_qneg_reg;
    assign a_side_in.ua   = s4_ua_reg;
    assign a_side_in.lo   = s4_lo_reg;
    assign a_side_in.hi   = s4_hi_reg;

    sct_divider #(
        .NUM_W  (GN_W),
        .DEN_W  (GD_W),
        .STEPS  (QSTEPS),
        .SIDE_W ($bits(g_side_t))
    ) u_gen_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (div_ctl),
        .num       ({s4_absnum_reg, {FRAC_BITS{1'b0}}}),
        .den       (s4_absarea_reg),
        .side_in   (g_side_in),
        .out_valid (g_div_valid),
        .quot      (g_quot),
        .side_out  (g_side_out)
    );

    sct_divider #(
        .NUM_W  (MW),
        .DEN_W  (DW),
        .STEPS  (QSTEPS),
        .SIDE_W ($bits(a_side_t))
    ) u_axis_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (div_ctl),
        .num       (s4_absprod_reg),
        .den       (s4_absdv_reg),
        .side_in   (a_side_in),
        .out_valid (a_div_valid),
        .quot      (a_quot),
        .side_out  (a_side_out)
    );

    // Post stage 1: clamp t, sign the axis quotient.
    logic                 p1_valid_reg;
    logic [1:0]           p1_op_reg;
    logic signed [CW-1:0] p1_x0_reg, p1_y0_reg;
    logic signed [DW-1:0] p1_aw_reg, p1_ah_reg;
    logic                 p1_gmiss_reg, p1_amiss_reg;
    logic [FRAC_BITS:0]   p1_t_reg;
    logic signed [QSTEPS:0] p1_sq_reg;
    logic signed [CW-1:0] p1_ua_reg, p1_lo_reg, p1_hi_reg;

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            p1_op_reg    <= g_side_out.op;
            p1_x0_reg    <= g_side_out.x0;
            p1_y0_reg    <= g_side_out.y0;
            p1_aw_reg    <= g_side_out.aw;
            p1_ah_reg    <= g_side_out.ah;
            p1_gmiss_reg <= g_side_out.miss;
            p1_t_reg     <= g_side_out.tzero ? '0 :
                            g_side_out.tone  ? G_ONE : {1'b0, g_quot[FRAC_BITS-1:0]};
            p1_amiss_reg <= a_side_out.miss;
            p1_sq_reg    <= a_side_out.qneg ? -signed'({1'b0, a_quot}) :
                                              signed'({1'b0, a_quot});
            p1_ua_reg    <= a_side_out.ua;
            p1_lo_reg    <= a_side_out.lo;
            p1_hi_reg    <= a_side_out.hi;
        end
    end

    // Post stage 2: surface extent times t; crossing coordinate.
    logic                 p2_valid_reg;
    logic [1:0]           p2_op_reg;
    logic signed [CW-1:0] p2_x0_reg, p2_y0_reg;
    logic                 p2_gmiss_reg, p2_amiss_reg;
    logic signed [GP_W-1:0] p2_gpx_reg, p2_gpy_reg;
    logic signed [UW-1:0] p2_u_reg;
    logic signed [CW-1:0] p2_lo_reg, p2_hi_reg;

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            p2_op_reg    <= p1_op_reg;
            p2_x0_reg    <= p1_x0_reg;
            p2_y0_reg    <= p1_y0_reg;
            p2_gmiss_reg <= p1_gmiss_reg;
            p2_amiss_reg <= p1_amiss_reg;
            p2_gpx_reg   <= GP_W'(p1_aw_reg) * GP_W'(signed'({1'b0, p1_t_reg}));
            p2_gpy_reg   <= GP_W'(p1_ah_reg) * GP_W'(signed'({1'b0, p1_t_reg}));
            p2_u_reg     <= UW'(p1_ua_reg) + UW'(p1_sq_reg);
            p2_lo_reg    <= p1_lo_reg;
            p2_hi_reg    <= p1_hi_reg;
        end
    end

    // Post stage 3: rounding bias toward zero; overshoot tests and snapping.
    logic signed [UW-1:0] p3_lo_ext, p3_hi_ext;
    logic                 p3_below, p3_above, p3_far;
    logic signed [CW-1:0] p3_aval_next;

    always_comb begin
        p3_lo_ext = UW'(p2_lo_reg);
        p3_hi_ext = UW'(p2_hi_reg);
        p3_below  = p2_u_reg < p3_lo_ext;
        p3_above  = p2_u_reg > p3_hi_ext;
        p3_far    = (p3_below && p2_u_reg < p3_lo_ext - a_et) ||
                    (p3_above && p2_u_reg > p3_hi_ext + a_et);
        p3_aval_next = p3_below ? p2_lo_reg :
                       p3_above ? p2_hi_reg : p2_u_reg[CW-1:0];
    end

    logic                 p3_valid_reg;
    logic [1:0]           p3_op_reg;
    logic signed [CW-1:0] p3_x0_reg, p3_y0_reg;
    logic                 p3_ghit_reg, p3_ahit_reg;
    logic signed [GP_W-1:0] p3_gbx_reg, p3_gby_reg;
    logic signed [CW-1:0] p3_aval_reg;

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            p3_op_reg   <= p2_op_reg;
            p3_x0_reg   <= p2_x0_reg;
            p3_y0_reg   <= p2_y0_reg;
            p3_ghit_reg <= !p2_gmiss_reg;
            p3_ahit_reg <= !p2_amiss_reg && !p3_far;
            p3_gbx_reg  <= p2_gpx_reg + (p2_gpx_reg[GP_W-1] ? G_BIAS : GP_W'(0));
            p3_gby_reg  <= p2_gpy_reg + (p2_gpy_reg[GP_W-1] ? G_BIAS : GP_W'(0));
            p3_aval_reg <= p3_aval_next;
        end
    end

    // Output register.
    logic                 out_hit_next;
    logic signed [CW-1:0] out_cx_next, out_cy_next;

    always_comb begin
        case (p3_op_reg)
            sct_pkg::OP_GENERAL: begin
                out_hit_next = p3_ghit_reg;
                out_cx_next  = p3_x0_reg + CW'(p3_gbx_reg >>> FRAC_BITS);
                out_cy_next  = p3_y0_reg + CW'(p3_gby_reg >>> FRAC_BITS);
            end
            sct_pkg::OP_HORIZ: begin
                out_hit_next = p3_ahit_reg;
                out_cx_next  = p3_aval_reg;
                out_cy_next  = p3_y0_reg;
            end
            sct_pkg::OP_VERT: begin
                out_hit_next = p3_ahit_reg;
                out_cx_next  = p3_x0_reg;
                out_cy_next  = p3_aval_reg;
            end
            default: begin
                out_hit_next = 1'b0;
                out_cx_next  = '0;
                out_cy_next  = '0;
            end
        endcase
        if (!out_hit_next) begin
            out_cx_next = '0;
            out_cy_next = '0;
        end
    end

    logic                 out_hit_reg;
    logic signed [CW-1:0] out_cx_reg, out_cy_reg;

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            out_hit_reg <= out_hit_next;
            out_cx_reg  <= out_cx_next;
            out_cy_reg  <= out_cy_next;
        end
    end

    // Valid bits of the stages outside the dividers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (pipe_adv) begin
            s1_valid_reg  <= s_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            p1_valid_reg  <= g_div_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            out_valid_reg <= p3_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = OUT_W'({out_cy_reg, out_cx_reg});

    // Checks.
    `SCT_ASSERT_IMPL(a_div_lanes_agree, aclk, aresetn, 1'b1, g_div_valid == a_div_valid, "divider lanes out of step")
    `SCT_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0, "miss with nonzero contact")
    `SCT_ASSERT_IMPL(a_t_range, aclk, aresetn, p1_valid_reg, p1_t_reg <= G_ONE, "t above one")
    `SCT_ASSERT_NEXT(a_out_fill, aclk, aresetn, p3_valid_reg && pipe_adv, m_tvalid, "item lost before output")

endmodule

/* sim/segment_crossing_checker.sv */
// Watches the stream and configuration channels of the segment crossing test block,
// predicts every result from its own copy of the tolerances and compares in order.
// Depends on sct_pkg for the register indexes, opcodes and tolerance reset values.
module segment_crossing_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [255:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic         m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           fail_count,
    output int           pending
);
    import sct_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic              hit;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } contact_t;

    contact_t      contact_q[$];
    logic [15:0]   near_tol;
    logic [15:0]   edge_tol;

    function automatic wide_t wmin(input wide_t a, input wide_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic wide_t wmax(input wide_t a, input wide_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic wide_t wabs(input wide_t a);
        return (a < 0) ? -a : a;
    endfunction

    // Crossing of an axis-aligned surface at level c; u runs along it, v across it.
    function automatic logic axis_crossing(input wide_t c, input wide_t s0, input wide_t s1,
                                           input wide_t ua, input wide_t va,
                                           input wide_t ub, input wide_t vb,
                                           input logic a_below, output wide_t pos);
        wide_t n, e, lo, hi, dv, du, u;
        n = near_tol;
        e = edge_tol;
        lo = wmin(s0, s1);
        hi = wmax(s0, s1);
        pos = 0;
        if ((ua < lo && ub < lo) || (hi < ua && hi < ub)) return 0;
        if (a_below) begin
            if (va - c < -n || vb - c > n) return 0;
        end else begin
            if (vb - c < -n || va - c > n) return 0;
        end
        dv = vb - va;
        du = ub - ua;
        if (dv == 0 || wabs(dv) < n) return 0;
        u = ua + (du * (c - va)) / dv;
        if (u < lo) begin
            if (u < lo - e) return 0;
            pos = lo;
        end else if (u > hi) begin
            if (u > hi + e) return 0;
            pos = hi;
        end else begin
            pos = u;
        end
        return 1;
    endfunction

    function automatic logic general_crossing(input wide_t x0, input wide_t y0,
                                              input wide_t x1, input wide_t y1,
                                              input wide_t ax, input wide_t ay,
                                              input wide_t bx, input wide_t by,
                                              output wide_t ox, output wide_t oy);
        wide_t etol, ntol, one, aw, ah, d0x, d0y, d1x, d1y, bw, bh;
        wide_t h0, h1, det, area, num, t;
        logic below0, above1;
        etol = wide_t'(edge_tol) <<< 16;
        ntol = wide_t'(near_tol) <<< 16;
        one = wide_t'(1) <<< 16;
        aw = x1 - x0;  ah = y1 - y0;
        d0x = ax - x0; d0y = ay - y0;
        d1x = bx - x1; d1y = by - y1;
        bw = bx - ax;  bh = by - ay;
        ox = 0;
        oy = 0;
        if ((ax < wmin(x0, x1) && bx < wmin(x0, x1)) ||
            (wmax(x0, x1) < ax && wmax(x0, x1) < bx)) return 0;
        if ((ay < wmin(y0, y1) && by < wmin(y0, y1)) ||
            (wmax(y0, y1) < ay && wmax(y0, y1) < by)) return 0;
        h0 = aw * d0y - ah * d0x;
        below0 = h0 < 0;
        if (below0 && h0 < -etol) return 0;
        h1 = aw * d1y - ah * d1x;
        above1 = h1 > 0;
        if (above1 && h1 > etol) return 0;
        if (h0 == 0 && h1 == 0) return 0;
        det = d0x * d1y - d0y * d1x;
        if ((det < h0 && det < h1) || (det > h0 && det > h1)) return 0;
        if ((bw == 0 && bh == 0) || (below0 && above1) || (!below0 && above1)) return 0;
        area = bw * ah - bh * aw;
        if (!(wabs(area) > ntol)) return 0;
        num = bw * d0y - bh * d0x;
        if (num == 0 || ((num < 0) != (area < 0))) begin
            t = 0;
        end else begin
            t = (wabs(num) <<< 16) / wabs(area);
            if (t > one) t = one;
        end
        ox = x0 + (aw * t) / one;
        oy = y0 + (ah * t) / one;
        return 1;
    endfunction

    function automatic contact_t predict_contact(input logic [1:0] op,
                                                 input logic [255:0] pts);
        contact_t r;
        wide_t c[8];
        wide_t ox, oy;
        logic hit;
        for (int i = 0; i < 8; i++) c[i] = $signed(pts[32*i +: 32]);
        ox = 0;
        oy = 0;
        hit = 0;
        case (op)
            OP_GENERAL: hit = general_crossing(c[0], c[1], c[2], c[3], c[4], c[5],
                                               c[6], c[7], ox, oy);
            OP_HORIZ: begin
                hit = axis_crossing(c[1], c[0], c[2], c[4], c[5], c[6], c[7],
                                    c[0] < c[2], ox);
                oy = c[1];
            end
            OP_VERT: begin
                hit = axis_crossing(c[0], c[1], c[3], c[5], c[4], c[7], c[6],
                                    !(c[1] < c[3]), oy);
                ox = c[0];
            end
            default: hit = 0;
        endcase
        r.hit = hit;
        r.cx = hit ? ox[31:0] : '0;
        r.cy = hit ? oy[31:0] : '0;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("MISMATCH at %0t: %s expected %h got %h", $time, what, want, got);
        fail_count++;
    endtask

    assign pending = contact_q.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        contact_t want;
        if (!aresetn) begin
            near_tol <= NEAR_TOL_RESET;
            edge_tol <= EDGE_TOL_RESET;
            contact_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_NEAR_TOL) near_tol <= cfg_data;
                else if (cfg_index == REG_EDGE_TOL) edge_tol <= cfg_data;
            end
            if (s_tvalid && s_tready)
                contact_q.push_back(predict_contact(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (contact_q.size() == 0) begin
                    report("unexpected item", 32'h0, m_tdata[31:0]);
                end else begin
                    want = contact_q.pop_front();
                    if (m_tuser !== want.hit) report("hit", want.hit, m_tuser);
                    if (m_tdata[31:0] !== want.cx) report("contact_x", want.cx, m_tdata[31:0]);
                    if (m_tdata[63:32] !== want.cy) report("contact_y", want.cy, m_tdata[63:32]);
                end
            end
        end
    end

endmodule

/* sim/tb_segment_crossing_test.sv */
// Stimulus and verdict for the segment crossing test block: directed and random
// segment pairs under several tolerance settings with random stalls on both sides.
// Depends on sct_pkg, segment_crossing_test and segment_crossing_checker.
module tb_segment_crossing_test;
    import sct_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] REG_NONE  = 8'd2;
    localparam int ONE = 32'sh10000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [63:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [7:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;
    int           fail_count;
    int           pending;
    logic         send_idle = 1;
    logic         recv_idle = 1;

    always #4 aclk = ~aclk;

    segment_crossing_test uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    segment_crossing_checker contact_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    task automatic send_query(input logic [1:0] op, input int x0, input int y0,
                              input int x1, input int y1, input int ax, input int ay,
                              input int bx, input int by);
        int gap;
        gap = send_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {by, bx, ay, ax, y1, x1, y0, x0};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
    endtask

    task automatic write_tol(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    function automatic int near_coord();
        return int'($urandom_range(0, 1 << 22)) - (1 << 21);
    endfunction

    // Random pair: a surface and a motion through a point on it, with some jitter
    // so that the tolerance edges get hit; a few items are pure noise.
    task automatic send_random();
        logic [1:0] op;
        int x0, y0, x1, y1, px, py, dx, dy, k, ax, ay, bx, by;
        op = ($urandom_range(0, 40) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0) begin
            send_query(op, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
            return;
        end
        x0 = near_coord(); y0 = near_coord(); x1 = near_coord(); y1 = near_coord();
        if (op == OP_HORIZ) y1 = y0;
        if (op == OP_VERT) x1 = x0;
        k = $urandom_range(0, 256) + ($urandom_range(0, 3) == 0 ? 24 : 0) - 12;
        px = x0 + int'((longint'(x1 - x0) * k) / 256);
        py = y0 + int'((longint'(y1 - y0) * k) / 256);
        dx = near_coord() / ($urandom_range(0, 1) ? 1 : 64);
        dy = near_coord() / ($urandom_range(0, 1) ? 1 : 64);
        k = $urandom_range(1, 8);
        ax = px + dx; ay = py + dy;
        bx = px - dx * k / 4; by = py - dy * k / 4;
        if ($urandom_range(0, 2) == 0) begin
            bx += int'($urandom_range(0, 20000)) - 10000;
            by += int'($urandom_range(0, 20000)) - 10000;
        end
        if ($urandom_range(0, 30) == 0) begin
            bx = ax; by = ay;
        end
        if ($urandom_range(0, 1)) send_query(op, x0, y0, x1, y1, ax, ay, bx, by);
        else send_query(op, x0, y0, x1, y1, bx, by, ax, ay);
    endtask

    task automatic send_directed();
        int lo, hi;
        lo = 32'sh8000_0000;
        hi = 32'sh7fff_ffff;
        for (int op = 0; op < 4; op++) begin
            send_query(2'(op), lo, lo, lo, lo, lo, lo, lo, lo);
            send_query(2'(op), hi, hi, hi, hi, hi, hi, hi, hi);
            send_query(2'(op), lo, hi, hi, lo, hi, lo, lo, hi);
        end
        // Plain crossings of each kind.
        send_query(OP_GENERAL, 0, 0, 2 * ONE, 0, ONE, ONE, ONE, -ONE);
        send_query(OP_GENERAL, 0, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE, 0);
        send_query(OP_HORIZ, 0, 0, ONE, 0, ONE / 2, ONE, ONE / 2, -ONE);
        send_query(OP_VERT, 0, 0, 0, ONE, -ONE, ONE / 2, ONE, ONE / 2);
        // Overshoot past the surface end: snapped, too far, then snapped below the low end.
        send_query(OP_HORIZ, 0, 0, ONE, 0, 70000, ONE, 70000, -ONE);
        send_query(OP_HORIZ, 0, 0, ONE, 0, 80000, ONE, 80000, -ONE);
        send_query(OP_VERT, 0, ONE, 0, 0, -ONE, -3000, ONE, -3000);
        // Zero motion extent across the surface.
        send_query(OP_HORIZ, 0, 0, ONE, 0, 100, 0, 200, 0);
        send_query(OP_VERT, 0, 0, 0, ONE, 0, 100, 0, 200);
        // Collinear motion, zero-length motion, parallel motion.
        send_query(OP_GENERAL, 0, 0, 2 * ONE, 0, ONE / 2, 0, ONE, 0);
        send_query(OP_GENERAL, 0, 0, 2 * ONE, 0, ONE, 0, ONE, 0);
        send_query(OP_GENERAL, 0, 0, 2 * ONE, 0, ONE, 5, 2 * ONE, 5);
    endtask

    // Receiver: a random stall before each item unless stalls are off.
    initial begin
        int n;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            n = recv_idle ? 0 : $urandom_range(0, 14);
            if (n > 0) begin
                m_tready <= 0;
                repeat (n) @(negedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    initial begin
        logic [15:0] near_set[6];
        logic [15:0] edge_set[6];
        near_set = '{16'd7, 16'd0, 16'hffff, 16'd7, 16'd300, 16'd1};
        edge_set = '{16'd6554, 16'd0, 16'hffff, 16'd20000, 16'd100, 16'd6554};
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                wait (pending == 0);
                repeat (60) @(negedge aclk);
                near_set[4] = 16'($urandom);
                edge_set[4] = 16'($urandom);
                write_tol(REG_NEAR_TOL, near_set[phase]);
                write_tol(REG_EDGE_TOL, edge_set[phase]);
                if (phase == 3) write_tol(REG_NONE, 16'($urandom));
            end
            if (phase == 0) send_directed();
            for (int i = 0; i < 275; i++) begin
                if (i % 50 == 0) begin
                    send_idle = ($urandom_range(0, 3) == 0);
                    recv_idle = ($urandom_range(0, 3) == 0);
                end
                send_random();
            end
            s_tvalid <= 0;
        end
        wait (pending == 0);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) $display("segment_crossing_test verification clean");
        else $display("segment_crossing_test verification failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("segment_crossing_test verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/sct_pkg.sv
rtl/sct_divider.sv
rtl/segment_crossing_test.sv
sim/segment_crossing_checker.sv
sim/tb_segment_crossing_test.sv
